@@ hw/rtl/bzc_pkg.sv @@
// Shared types, constants and helper functions for the back-EMF zero-cross tracker.
package bzc_pkg;

    // Time width default and fixed arithmetic widths
    localparam int TIME_W_DEFAULT = 32;
    localparam int DIV_W          = 24;
    localparam int RPM_W          = 20;
    localparam int PERIOD_W       = 32;

    localparam logic [DIV_W-1:0] RPM_SCALE   = 24'd10000000;
    localparam logic [RPM_W-1:0] RPM_MAX     = 20'd1000000;
    // below this period the electrical rpm saturates at RPM_MAX
    localparam logic [DIV_W-1:0] DT_SAT_LIM  = 24'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SECTOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VBUS_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS   = 3'd5;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic        RST_DIRECTION   = 1'b0;
    localparam logic [15:0] RST_VBUS_MIN    = 16'd5000;
    localparam logic [14:0] RST_ZERO_THRESH = 15'd50;
    localparam logic [15:0] RST_MIN_PERIOD  = 16'd10;
    localparam logic [6:0]  RST_POLE_PAIRS  = 7'd7;
    localparam logic [2:0]  RST_SECTOR      = 3'd0;

    // Phase codes
    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_ZERO = 2'd0,
        REG_POS  = 2'd1,
        REG_NEG  = 2'd2
    } region_t;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_LOW   = 2'd1,
        CMD_CROSS = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_DIV_E = 2'd1,
        B_DIV_M = 2'd2,
        B_EMIT  = 2'd3
    } back_state_t;

    typedef struct packed {
        logic        direction;
        logic [15:0] vbus_min_mv;
        logic [14:0] zero_thresh_mv;
        logic [15:0] min_period_us;
    } front_cfg_t;

    // Classified sample handed from front to back
    typedef struct packed {
        cmd_kind_t            kind;
        logic [2:0]           sector;
        logic [1:0]           fphase;
        logic                 dt_big;   // interval >= 2^DIV_W, speed is zero
        logic [DIV_W-1:0]     dt_lo;
        logic [PERIOD_W-1:0]  period;
    } cmd_t;

    typedef struct packed {
        logic [2:0]          sector_now;
        logic [1:0]          floating_phase;
        logic                crossing_accepted;
        logic                speed_valid;
        logic                zero_seen;
        logic [RPM_W-1:0]    rpm_electrical;
        logic [RPM_W-1:0]    rpm_mechanical;
        logic [PERIOD_W-1:0] period_us;
    } res_t;

    function automatic logic [1:0] open_phase(input logic [2:0] sector);
        logic [1:0] ph;
        case (sector)
            3'd0:    ph = PH_W;
            3'd1:    ph = PH_V;
            3'd2:    ph = PH_U;
            3'd3:    ph = PH_W;
            3'd4:    ph = PH_V;
            3'd5:    ph = PH_U;
            default: ph = PH_U;
        endcase
        return ph;
    endfunction

    function automatic logic [2:0] mod6(input logic [2:0] v);
        return (v >= 3'd6) ? 3'(v - 3'd6) : v;
    endfunction

    function automatic logic [2:0] step_sector(input logic [2:0] s, input logic dir);
        logic [2:0] r;
        if (!dir)
        begin
            r = (s >= 3'd5) ? 3'd0 : 3'(s + 3'd1);
        end
        else
        begin
            r = (s == 3'd0) ? 3'd5 : 3'(s - 3'd1);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/bzc_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module bzc_div
    import bzc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = CW'(cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/bzc_queue.sv @@
// Two-entry command queue between front and back.
module bzc_queue
    import bzc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t              mem [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        case ({push, pop})
            2'b10:   count_next = (PW+1)'(count_reg + 1'b1);
            2'b01:   count_next = (PW+1)'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ hw/rtl/bzc_front.sv @@
// Front end: takes samples, classifies the floating phase, decides crossings.
module bzc_front
    import bzc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEFAULT
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_us,
    input  logic [15:0]        vbus_mv,
    input  logic signed [15:0] phase_u_mv,
    input  logic signed [15:0] phase_v_mv,
    input  logic signed [15:0] phase_w_mv,
    input  logic               sec_load,
    input  logic [2:0]         sec_load_val,
    input  front_cfg_t         cfg,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    logic [2:0]            sector_reg, sector_next;
    region_t               prev_region_reg, prev_region_next;
    logic [TIME_WIDTH-1:0] last_cross_reg, last_cross_next;

    logic                  take;
    logic [1:0]            fp;
    logic signed [15:0]    v_sel;
    logic signed [16:0]    v_ext;
    logic signed [16:0]    th_pos;
    logic signed [16:0]    th_neg;
    region_t               region;
    logic                  low_bus;
    logic                  crossed;
    logic                  accept;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] dt;
    logic [63:0]           dt_wide;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    assign fp = open_phase(sector_reg);

    always_comb
    begin
        case (fp)
            PH_U:    v_sel = phase_u_mv;
            PH_V:    v_sel = phase_v_mv;
            PH_W:    v_sel = phase_w_mv;
            default: v_sel = phase_u_mv;
        endcase
    end

    assign v_ext  = 17'(v_sel);
    assign th_pos = signed'({2'b00, cfg.zero_thresh_mv});
    assign th_neg = -th_pos;

    always_comb
    begin
        if (v_ext > th_pos)
        begin
            region = REG_POS;
        end
        else if (v_ext < th_neg)
        begin
            region = REG_NEG;
        end
        else
        begin
            region = REG_ZERO;
        end
    end

    assign low_bus = (vbus_mv < cfg.vbus_min_mv);
    assign crossed = (prev_region_reg == REG_NEG) && (region != REG_NEG);
    assign now_t   = TIME_WIDTH'(now_us);
    assign dt      = now_t - last_cross_reg;          // wraps mod 2^TIME_WIDTH
    assign dt_wide = 64'(dt);
    assign accept  = !low_bus && crossed && (dt >= TIME_WIDTH'(cfg.min_period_us));

    always_comb
    begin
        sector_next      = sector_reg;
        prev_region_next = prev_region_reg;
        last_cross_next  = last_cross_reg;
        q_push           = 1'b0;
        q_cmd.kind       = CMD_HOLD;
        q_cmd.fphase     = fp;
        q_cmd.dt_big     = |dt_wide[63:DIV_W];
        q_cmd.dt_lo      = dt_wide[DIV_W-1:0];
        q_cmd.period     = dt_wide[PERIOD_W-1:0];
        if (take)
        begin
            q_push = 1'b1;
            if (low_bus)
            begin
                q_cmd.kind = CMD_LOW;
            end
            else
            begin
                prev_region_next = region;
                if (accept)
                begin
                    q_cmd.kind      = CMD_CROSS;
                    last_cross_next = now_t;
                    sector_next     = step_sector(sector_reg, cfg.direction);
                end
            end
        end
        q_cmd.sector = sector_next;
        // start sector write reloads the sector; the user must keep the block idle then, the block does not enforce it
        if (sec_load)
        begin
            sector_next = mod6(sec_load_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_reg      <= RST_SECTOR;
            prev_region_reg <= REG_ZERO;
            last_cross_reg  <= '0;
        end
        else
        begin
            sector_reg      <= sector_next;
            prev_region_reg <= prev_region_next;
            last_cross_reg  <= last_cross_next;
        end
    end

endmodule

@@ hw/rtl/bzc_back.sv @@
// Back end: speed computation on a shared divider, status flags, output register.
module bzc_back
    import bzc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    input  logic [6:0] pole_pairs,
    output logic       out_valid,
    input  logic       out_ready,
    output res_t       res
);

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic                valid_flag_reg, valid_flag_next;
    logic                zero_seen_reg, zero_seen_next;
    logic [RPM_W-1:0]    rpm_e_reg, rpm_e_next;
    logic [RPM_W-1:0]    rpm_m_reg, rpm_m_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                out_valid_reg, out_valid_next;
    res_t                res_reg, res_next;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic [DIV_W-1:0]    pp_div;

    assign pp_div = (pole_pairs == 7'd0) ? DIV_W'(1) : DIV_W'(pole_pairs);

    bzc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        valid_flag_next = valid_flag_reg;
        zero_seen_next  = zero_seen_reg;
        rpm_e_next      = rpm_e_reg;
        rpm_m_next      = rpm_m_reg;
        period_next     = period_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        res_next        = res_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        div_dividend    = RPM_SCALE;
        div_divisor     = pp_div;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.kind)
                        CMD_LOW:
                        begin
                            valid_flag_next = 1'b0;
                            rpm_e_next      = '0;
                            rpm_m_next      = '0;
                            period_next     = '0;
                            state_next      = B_EMIT;
                        end
                        CMD_CROSS:
                        begin
                            valid_flag_next = 1'b1;
                            zero_seen_next  = 1'b1;
                            period_next     = q_cmd.period;
                            if (q_cmd.dt_big)
                            begin
                                rpm_e_next = '0;
                                rpm_m_next = '0;
                                state_next = B_EMIT;
                            end
                            else if (q_cmd.dt_lo < DT_SAT_LIM)
                            begin
                                rpm_e_next   = RPM_MAX;
                                div_start    = 1'b1;
                                div_dividend = DIV_W'(RPM_MAX);
                                state_next   = B_DIV_M;
                            end
                            else
                            begin
                                div_start    = 1'b1;
                                div_divisor  = q_cmd.dt_lo;
                                state_next   = B_DIV_E;
                            end
                        end
                        default:
                        begin
                            state_next = B_EMIT;
                        end
                    endcase
                end
            end
            B_DIV_E:
            begin
                if (div_done)
                begin
                    rpm_e_next   = div_q[RPM_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(div_q[RPM_W-1:0]);
                    state_next   = B_DIV_M;
                end
            end
            B_DIV_M:
            begin
                if (div_done)
                begin
                    rpm_m_next = div_q[RPM_W-1:0];
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    res_next.sector_now        = cmd_reg.sector;
                    res_next.floating_phase    = cmd_reg.fphase;
                    res_next.crossing_accepted = (cmd_reg.kind == CMD_CROSS);
                    res_next.speed_valid       = valid_flag_reg;
                    res_next.zero_seen         = zero_seen_reg;
                    res_next.rpm_electrical    = rpm_e_reg;
                    res_next.rpm_mechanical    = rpm_m_reg;
                    res_next.period_us         = period_reg;
                    state_next                 = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            valid_flag_reg <= 1'b0;
            zero_seen_reg  <= 1'b0;
            rpm_e_reg      <= '0;
            rpm_m_reg      <= '0;
            period_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_flag_reg <= valid_flag_next;
            zero_seen_reg  <= zero_seen_next;
            rpm_e_reg      <= rpm_e_next;
            rpm_m_reg      <= rpm_m_next;
            period_reg     <= period_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

@@ hw/rtl/bemf_zero_cross_sector_tracker_core.sv @@
// Top level of the sensorless BLDC back-EMF zero-cross sector tracker.
//
// One input word per ADC sample (timestamp, bus voltage, three phase voltages
// against neutral) yields exactly one output word. The front end classifies
// the floating phase of the current sector against the zero band, detects the
// negative-to-non-negative crossing, applies the minimum-period filter and
// steps the sector in the same cycle it takes the word; it then hands a
// command to a two-deep queue. The back end turns accepted crossings into
// speeds with one shared 24-bit restoring divider (one quotient bit per
// clock): 10^7 / period, then that result / pole pairs. A sample without an
// accepted crossing, or with a crossing of 2^24 us or more, needs no division;
// a crossing under 10 us needs one (the saturated rpm / pole pairs), and any
// other crossing needs both. The back end takes no new word from the queue
// until it has handed the current one to the output register, so the divider
// sets the sustained rate. The front keeps taking samples while the back is
// dividing until the queue fills, and the output register holds a finished
// word while the back end already works on the next.
// Intervals wrap modulo 2^TIME_WIDTH. Periods under 10 us saturate
// electrical rpm at 1000000; periods of 2^24 us or more give zero rpm.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must only be made while the block is idle; writing the initial-sector
// register also reloads the sector (mod six).
module bemf_zero_cross_sector_tracker_core
    import bzc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample input word
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           now_us,
    input  logic [15:0]           vbus_mv,
    input  logic signed [15:0]    phase_u_mv,
    input  logic signed [15:0]    phase_v_mv,
    input  logic signed [15:0]    phase_w_mv,
    // result output word
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            sector_now,
    output logic [1:0]            floating_phase,
    output logic                  crossing_accepted,
    output logic                  speed_valid,
    output logic                  zero_seen,
    output logic [RPM_W-1:0]      rpm_electrical,
    output logic [RPM_W-1:0]      rpm_mechanical,
    output logic [PERIOD_W-1:0]   period_us
);

    // Configuration registers
    logic        direction_reg;
    logic [15:0] vbus_min_reg;
    logic [14:0] zero_thresh_reg;
    logic [15:0] min_period_reg;
    logic [6:0]  pole_pairs_reg;

    front_cfg_t  front_cfg;
    logic        sec_load;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;
    res_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= RST_DIRECTION;
            vbus_min_reg    <= RST_VBUS_MIN;
            zero_thresh_reg <= RST_ZERO_THRESH;
            min_period_reg  <= RST_MIN_PERIOD;
            pole_pairs_reg  <= RST_POLE_PAIRS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIRECTION:   direction_reg   <= cfg_wdata[0];
                CFG_VBUS_MIN:    vbus_min_reg    <= cfg_wdata;
                CFG_ZERO_THRESH: zero_thresh_reg <= cfg_wdata[14:0];
                CFG_MIN_PERIOD:  min_period_reg  <= cfg_wdata;
                CFG_POLE_PAIRS:  pole_pairs_reg  <= cfg_wdata[6:0];
                default:         ;   // start sector lives in the front; others ignored
            endcase
        end
    end

    assign sec_load = cfg_we && (cfg_index == CFG_INIT_SECTOR);

    assign front_cfg.direction      = direction_reg;
    assign front_cfg.vbus_min_mv    = vbus_min_reg;
    assign front_cfg.zero_thresh_mv = zero_thresh_reg;
    assign front_cfg.min_period_us  = min_period_reg;

    bzc_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .now_us       (now_us),
        .vbus_mv      (vbus_mv),
        .phase_u_mv   (phase_u_mv),
        .phase_v_mv   (phase_v_mv),
        .phase_w_mv   (phase_w_mv),
        .sec_load     (sec_load),
        .sec_load_val (cfg_wdata[2:0]),
        .cfg          (front_cfg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    bzc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    bzc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .pole_pairs (pole_pairs_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    assign sector_now        = res.sector_now;
    assign floating_phase    = res.floating_phase;
    assign crossing_accepted = res.crossing_accepted;
    assign speed_valid       = res.speed_valid;
    assign zero_seen         = res.zero_seen;
    assign rpm_electrical    = res.rpm_electrical;
    assign rpm_mechanical    = res.rpm_mechanical;
    assign period_us         = res.period_us;

endmodule

@@ hw/rtl/bzc_checker.sv @@
// Port-level assertions for the tracker, bound to the top level.
module bzc_checker
    import bzc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [2:0]          sector_now,
    input logic [1:0]          floating_phase,
    input logic                crossing_accepted,
    input logic                speed_valid,
    input logic                zero_seen,
    input logic [RPM_W-1:0]    rpm_electrical,
    input logic [RPM_W-1:0]    rpm_mechanical,
    input logic [PERIOD_W-1:0] period_us
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sector_now)
            && $stable(floating_phase)
            && $stable(rpm_electrical) && $stable(period_us))
        else $error("output word changed while stalled");

    // an accepted crossing always leaves valid speed and the seen flag
    a_cross_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crossing_accepted |-> speed_valid && zero_seen)
        else $error("crossing without valid/seen flags");

    // without a valid measurement all speed fields read zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !speed_valid |->
            rpm_electrical == '0 && rpm_mechanical == '0 && period_us == '0)
        else $error("speed fields nonzero while invalid");

    // mechanical speed never exceeds electrical
    a_mech_le_elec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rpm_mechanical <= rpm_electrical)
        else $error("mechanical rpm above electrical rpm");

endmodule

bind bemf_zero_cross_sector_tracker_core bzc_checker u_bzc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .sector_now        (sector_now),
    .floating_phase    (floating_phase),
    .crossing_accepted (crossing_accepted),
    .speed_valid       (speed_valid),
    .zero_seen         (zero_seen),
    .rpm_electrical    (rpm_electrical),
    .rpm_mechanical    (rpm_mechanical),
    .period_us         (period_us)
);
